### rtl/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int PULSE_WIDTH = 4;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [1:0] REG_LOAD  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_CTRL  = 2'd2;
  localparam logic [1:0] REG_FLAG  = 2'd3;

  typedef struct packed {
    logic [1:0]            mode;
    logic [1:0]            channel;
    logic [1:0]            reg_select;
    logic [DATA_WIDTH-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  read_data;
    logic                   irq;
    logic [PULSE_WIDTH-1:0] timeout_pulses;
  } rsp_t;

  typedef struct packed {
    logic                  tick;
    logic                  wr_load;
    logic                  wr_ctrl;
    logic                  wr_flag;
    logic [DATA_WIDTH-1:0] data;
  } chan_op_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] load_value;
    logic [COUNT_WIDTH-1:0] count;
    logic                   timer_enable;
    logic                   interrupt_enable;
    logic                   flag;
    logic                   irq_next;
    logic                   pulse;
  } chan_stat_t;

endpackage

### rtl/pit_channel.sv
`timescale 1ns / 1ps

module pit_channel (
  input  logic                clk,
  input  logic                rst,
  input  pit_pkg::chan_op_t   op,
  output pit_pkg::chan_stat_t stat
);

  logic [pit_pkg::COUNT_WIDTH-1:0] load_value, load_value_next;
  logic [pit_pkg::COUNT_WIDTH-1:0] count, count_next;
  logic                            timer_enable, timer_enable_next;
  logic                            interrupt_enable, interrupt_enable_next;
  logic                            flag, flag_next;
  logic                            pulse;

  always_comb begin
    load_value_next       = load_value;
    count_next            = count;
    timer_enable_next     = timer_enable;
    interrupt_enable_next = interrupt_enable;
    flag_next             = flag;
    pulse                 = 1'b0;
    if (op.tick && timer_enable) begin
      if (count == '0) begin
        flag_next  = 1'b1;
        count_next = load_value;
        pulse      = 1'b1;
      end else begin
        count_next = count - pit_pkg::COUNT_WIDTH'(1);
      end
    end
    if (op.wr_load) begin
      load_value_next = op.data[pit_pkg::COUNT_WIDTH-1:0];
    end
    if (op.wr_ctrl) begin
      // rising enable reloads the counter
      if (op.data[0] && !timer_enable) begin
        count_next = load_value;
      end
      timer_enable_next     = op.data[0];
      interrupt_enable_next = op.data[1];
    end
    if (op.wr_flag && op.data[0]) begin
      flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value       <= '0;
      count            <= '0;
      timer_enable     <= 1'b0;
      interrupt_enable <= 1'b0;
      flag             <= 1'b0;
    end else begin
      load_value       <= load_value_next;
      count            <= count_next;
      timer_enable     <= timer_enable_next;
      interrupt_enable <= interrupt_enable_next;
      flag             <= flag_next;
    end
  end

  assign stat.load_value       = load_value;
  assign stat.count            = count;
  assign stat.timer_enable     = timer_enable;
  assign stat.interrupt_enable = interrupt_enable;
  assign stat.flag             = flag;
  assign stat.irq_next         = flag_next & interrupt_enable_next;
  assign stat.pulse            = pulse;

endmodule

### rtl/periodic_interrupt_timer_core.sv
`timescale 1ns / 1ps
// channel   handshake                  word
// req       req_valid / req_stall      pit_pkg::req_t (tick, read or write)
// rsp       rsp_valid / rsp_stall      pit_pkg::rsp_t (read data, irq, pulses)
// cfg       cfg_valid / cfg_ready      module_disable bit
//
// one word per cycle sustained while rsp_stall is low; a word passes the s1 input register, then the rsp register
// the channel state updates when a word leaves the input register for the output register
// synchronous reset clears all channel state; module_disable comes out of reset set
// a word is taken while a finished result waits on rsp_stall, as long as the input
// register is free; cfg_ready is always high

module periodic_interrupt_timer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pit_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pit_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  logic          module_disable;
  logic          s1_valid, s1_valid_next;
  pit_pkg::req_t s1;
  logic          adv;
  logic          accept;
  logic          rsp_valid_next;
  pit_pkg::rsp_t rsp_next;

  logic is_tick, is_read, is_write;

  logic [pit_pkg::CHANNELS-1:0] chan_sel;
  logic [pit_pkg::CHANNELS-1:0] pulses;
  logic [pit_pkg::CHANNELS-1:0] irq_bits;
  pit_pkg::chan_op_t            op   [pit_pkg::CHANNELS];
  pit_pkg::chan_stat_t          stat [pit_pkg::CHANNELS];

  logic [pit_pkg::DATA_WIDTH-1:0]  read_data;
  logic [pit_pkg::PULSE_WIDTH-1:0] pulse_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_disable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      module_disable <= cfg_data;
    end
  end

  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
  end

  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (s1.mode)
      pit_pkg::MODE_TICK:  is_tick  = 1'b1;
      pit_pkg::MODE_READ:  is_read  = 1'b1;
      pit_pkg::MODE_WRITE: is_write = 1'b1;
      default: ;
    endcase
  end

  for (genvar c = 0; c < pit_pkg::CHANNELS; c++) begin : g_chan
    assign chan_sel[c]   = (32'(s1.channel) == c);
    assign op[c].tick    = adv && is_tick && !module_disable;
    assign op[c].wr_load = adv && is_write && chan_sel[c] && (s1.reg_select == pit_pkg::REG_LOAD);
    assign op[c].wr_ctrl = adv && is_write && chan_sel[c] && (s1.reg_select == pit_pkg::REG_CTRL);
    assign op[c].wr_flag = adv && is_write && chan_sel[c] && (s1.reg_select == pit_pkg::REG_FLAG);
    assign op[c].data    = s1.write_data;

    pit_channel u_chan (
      .clk  (clk),
      .rst  (rst),
      .op   (op[c]),
      .stat (stat[c])
    );

    assign pulses[c]   = stat[c].pulse;
    assign irq_bits[c] = stat[c].irq_next;
  end

  for (genvar p = 0; p < pit_pkg::PULSE_WIDTH; p++) begin : g_pulse
    if (p < pit_pkg::CHANNELS) begin : g_live
      assign pulse_word[p] = pulses[p];
    end else begin : g_none
      assign pulse_word[p] = 1'b0;
    end
  end

  always_comb begin
    read_data = '0;
    for (int c = 0; c < pit_pkg::CHANNELS; c++) begin
      if (is_read && chan_sel[c]) begin
        case (s1.reg_select)
          pit_pkg::REG_LOAD:  read_data = pit_pkg::DATA_WIDTH'(stat[c].load_value);
          pit_pkg::REG_COUNT: read_data = pit_pkg::DATA_WIDTH'(stat[c].count);
          pit_pkg::REG_CTRL:  read_data = pit_pkg::DATA_WIDTH'({stat[c].interrupt_enable,
                                                                stat[c].timer_enable});
          default:            read_data = pit_pkg::DATA_WIDTH'(stat[c].flag);
        endcase
      end
    end
  end

  assign rsp_next.read_data      = read_data;
  assign rsp_next.irq            = |irq_bits;
  assign rsp_next.timeout_pulses = pulse_word;

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (adv) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_pulse_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    adv && (s1.mode != pit_pkg::MODE_TICK) |=> rsp.timeout_pulses == '0)
    else $error("timeout pulse on a non-tick word");

  a_disabled_no_pulse: assert property (@(posedge clk) disable iff (rst)
    adv && module_disable |=> rsp.timeout_pulses == '0)
    else $error("timeout pulse while module disabled");

  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    adv && (s1.mode != pit_pkg::MODE_READ) |=> rsp.read_data == '0)
    else $error("read data on a non-read word");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("input stalled without a blocked word");
`endif

endmodule

### sim/periodic_interrupt_timer_core_test.sv
`timescale 1ns / 1ps

module periodic_interrupt_timer_core_test;

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 5;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  // shadow of the timer channels, one expected word per accepted request
  class pit_timer_shadow;
    logic [pit_pkg::COUNT_WIDTH-1:0] reload_val [pit_pkg::CHANNELS];
    logic [pit_pkg::COUNT_WIDTH-1:0] count_val [pit_pkg::CHANNELS];
    bit run_en [pit_pkg::CHANNELS];
    bit irq_en [pit_pkg::CHANNELS];
    bit hit_flag [pit_pkg::CHANNELS];
    bit module_off;
    pit_pkg::rsp_t expected_rsp[$];
    int mismatches;

    function new();
      for (int c = 0; c < pit_pkg::CHANNELS; c++) begin
        reload_val[c] = '0;
        count_val[c] = '0;
        run_en[c] = 1'b0;
        irq_en[c] = 1'b0;
        hit_flag[c] = 1'b0;
      end
      module_off = 1'b1;
      mismatches = 0;
    endfunction

    function void note_request(pit_pkg::req_t w);
      pit_pkg::rsp_t e;
      int ch;
      e = '0;
      ch = int'(w.channel);
      case (w.mode)
        pit_pkg::MODE_TICK: begin
          if (!module_off) begin
            for (int c = 0; c < pit_pkg::CHANNELS; c++) begin
              if (run_en[c]) begin
                if (count_val[c] == '0) begin
                  hit_flag[c] = 1'b1;
                  count_val[c] = reload_val[c];
                  if (c < pit_pkg::PULSE_WIDTH) e.timeout_pulses[c] = 1'b1;
                end else begin
                  count_val[c] = count_val[c] - pit_pkg::COUNT_WIDTH'(1);
                end
              end
            end
          end
        end
        pit_pkg::MODE_READ: begin
          if (ch < pit_pkg::CHANNELS) begin
            case (w.reg_select)
              pit_pkg::REG_LOAD:  e.read_data = pit_pkg::DATA_WIDTH'(reload_val[ch]);
              pit_pkg::REG_COUNT: e.read_data = pit_pkg::DATA_WIDTH'(count_val[ch]);
              pit_pkg::REG_CTRL:  e.read_data = pit_pkg::DATA_WIDTH'({irq_en[ch], run_en[ch]});
              default:            e.read_data = pit_pkg::DATA_WIDTH'(hit_flag[ch]);
            endcase
          end
        end
        pit_pkg::MODE_WRITE: begin
          if (ch < pit_pkg::CHANNELS) begin
            case (w.reg_select)
              pit_pkg::REG_LOAD: reload_val[ch] = w.write_data[pit_pkg::COUNT_WIDTH-1:0];
              pit_pkg::REG_CTRL: begin
                if (w.write_data[0] && !run_en[ch]) count_val[ch] = reload_val[ch];
                run_en[ch] = w.write_data[0];
                irq_en[ch] = w.write_data[1];
              end
              pit_pkg::REG_FLAG: if (w.write_data[0]) hit_flag[ch] = 1'b0;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      for (int c = 0; c < pit_pkg::CHANNELS; c++) begin
        if (hit_flag[c] && irq_en[c]) e.irq = 1'b1;
      end
      expected_rsp.push_back(e);
    endfunction

    function void check_response(pit_pkg::rsp_t got);
      pit_pkg::rsp_t e;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: read_data %h irq %b pulses %b",
                   got.read_data, got.irq, got.timeout_pulses);
        return;
      end
      e = expected_rsp.pop_front();
      if (got.read_data !== e.read_data || got.irq !== e.irq ||
          got.timeout_pulses !== e.timeout_pulses) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: read_data exp %h got %h, irq exp %b got %b, pulses exp %b got %b",
                   e.read_data, got.read_data, e.irq, got.irq,
                   e.timeout_pulses, got.timeout_pulses);
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  pit_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pit_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  pit_timer_shadow board = new();
  int cycle_count = 0;
  int items_sent = 0;
  int hold_request = 0;
  int hold_left = 0;
  int style_left = 0;
  stall_style_e style = STALL_NONE;

  periodic_interrupt_timer_core u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : response_side
    logic stall_next;
    cycle_count++;
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);
    if (style_left == 0) begin
      style = stall_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(20, 150);
    end else begin
      style_left--;
    end
    case (style)
      STALL_LIGHT:    stall_next = ($urandom_range(0, 9) < 2);
      STALL_HEAVY:    stall_next = ($urandom_range(0, 9) < 7);
      STALL_PERIODIC: stall_next = ((cycle_count % 5) < 2);
      default:        stall_next = 1'b0;
    endcase
    // long hold-off so the block backs up into the request side
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      stall_next = 1'b1;
      hold_left--;
    end
    if (rst) stall_next = 1'b0;
    rsp_stall <= stall_next;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic pit_pkg::req_t make_word(logic [1:0] mode, logic [1:0] ch,
                                              logic [1:0] sel,
                                              logic [pit_pkg::DATA_WIDTH-1:0] data);
    pit_pkg::req_t w;
    w.mode = mode;
    w.channel = ch;
    w.reg_select = sel;
    w.write_data = data;
    return w;
  endfunction

  function automatic pit_pkg::req_t random_word();
    pit_pkg::req_t w;
    int pick;
    w.channel = 2'($urandom_range(0, 3));
    w.reg_select = 2'($urandom_range(0, 3));
    w.write_data = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.mode = pit_pkg::MODE_TICK;
    end else if (pick < 70) begin
      w.mode = pit_pkg::MODE_READ;
    end else if (pick < 96) begin
      w.mode = pit_pkg::MODE_WRITE;
      if (w.reg_select == pit_pkg::REG_LOAD && $urandom_range(0, 3) != 0)
        w.write_data = $urandom_range(0, 6);
    end else begin
      w.mode = MODE_IDLE;
    end
    return w;
  endfunction

  task automatic send_word(input pit_pkg::req_t w);
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(w);
    items_sent++;
  endtask

  task automatic idle_sender(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_disable(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.module_off = v;
  endtask

  // set up one channel with a short period and start it
  task automatic program_channel();
    logic [1:0] ch;
    logic [pit_pkg::DATA_WIDTH-1:0] ctrl;
    ch = 2'($urandom_range(0, 3));
    ctrl = $urandom;
    ctrl[0] = 1'b1;
    send_word(make_word(pit_pkg::MODE_WRITE, ch, pit_pkg::REG_LOAD, $urandom_range(0, 5)));
    if ($urandom_range(0, 1) == 0)
      send_word(make_word(pit_pkg::MODE_WRITE, ch, pit_pkg::REG_CTRL, '0));
    send_word(make_word(pit_pkg::MODE_WRITE, ch, pit_pkg::REG_CTRL, ctrl));
  endtask

  initial begin
    logic phase_setting [PHASES];
    int target;
    int burst;
    bit gapless;
    phase_setting = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ticks do nothing while the module is disabled
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_LOAD, 32'd2));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_CTRL, 32'd3));
    send_word(make_word(pit_pkg::MODE_TICK, 2'd0, pit_pkg::REG_LOAD, '0));
    send_word(make_word(pit_pkg::MODE_READ, 2'd0, pit_pkg::REG_COUNT, '0));
    drain();
    write_disable(1'b0);

    // count down to zero, flag and reload
    repeat (3) send_word(make_word(pit_pkg::MODE_TICK, 2'd3, pit_pkg::REG_FLAG, 32'hFFFF_FFFF));
    send_word(make_word(pit_pkg::MODE_READ, 2'd0, pit_pkg::REG_FLAG, '0));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_FLAG, 32'hFFFF_FFFE));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_FLAG, 32'd1));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_COUNT, 32'hFFFF_FFFF));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd1, pit_pkg::REG_LOAD, 32'hFFFF_FFFF));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd1, pit_pkg::REG_CTRL, 32'hFFFF_FFFD));
    // zero load times out on every tick
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd2, pit_pkg::REG_LOAD, '0));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd2, pit_pkg::REG_CTRL, 32'd3));
    repeat (2) send_word(make_word(pit_pkg::MODE_TICK, 2'd0, pit_pkg::REG_LOAD, '0));
    send_word(make_word(pit_pkg::MODE_READ, 2'd1, pit_pkg::REG_COUNT, '0));
    // new load while running, enable kept set
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_LOAD, 32'd5));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd0, pit_pkg::REG_CTRL, 32'd3));
    send_word(make_word(MODE_IDLE, 2'd1, pit_pkg::REG_CTRL, 32'hA5A5_5A5A));
    send_word(make_word(pit_pkg::MODE_READ, 2'd2, pit_pkg::REG_CTRL, '0));
    send_word(make_word(pit_pkg::MODE_READ, 2'd1, pit_pkg::REG_LOAD, '0));
    send_word(make_word(pit_pkg::MODE_READ, 2'd3, pit_pkg::REG_FLAG, '0));
    send_word(make_word(pit_pkg::MODE_WRITE, 2'd2, pit_pkg::REG_CTRL, '0));

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      write_disable(phase_setting[phase]);
      gapless = (phase == 2);
      if (phase == 2) hold_request = 300;
      target = items_sent + 100;
      while (items_sent < target) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          if ($urandom_range(0, 9) == 0) program_channel();
          else send_word(random_word());
        end
        if (!gapless && $urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      end
    end

    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
